### src/ism_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_pkg
// Types, codes and sizes shared by the integer stack machine modules.
// ----------------------------------------------------------------------------
package ism_pkg;

    localparam int StackDepth = 32;
    localparam int CountW     = $clog2(StackDepth + 1);
    localparam int AddrW      = $clog2(StackDepth);

    typedef enum logic [3:0] {
        OP_PUSH = 4'd0,
        OP_LIST = 4'd1,
        OP_POP  = 4'd2,
        OP_SWAP = 4'd3,
        OP_ADD  = 4'd4,
        OP_SUB  = 4'd5,
        OP_DIV  = 4'd6,
        OP_MUL  = 4'd7,
        OP_MOD  = 4'd8
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOARG   = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_SHORT   = 3'd3,
        ST_DIVZERO = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    // Classified instruction as the front end hands it to the back end.
    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] value;
        logic        present;
    } instr_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_RDWAIT,
        S_EXEC,
        S_DIV,
        S_WB1,
        S_WB2,
        S_TOPRD,
        S_TOPWAIT,
        S_RESULT,
        S_LRD,
        S_LWAIT,
        S_LOUT
    } state_t;

endpackage
`default_nettype wire

### src/ism_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_front
// Accepts instruction words and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ism_front
    import ism_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire instr_t in_word,
    output logic        q_valid,
    input  wire logic   q_ready,
    output instr_t      q_word
);

    instr_t     mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push, pop;

    assign in_ready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_word   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_word;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

### src/ism_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_div
// Signed 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ism_div
    import ism_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient,
    output logic [31:0]      remainder
);

    logic [31:0] quo_reg, den_reg;
    logic [32:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, qneg_reg, rneg_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {rem_reg[31:0], quo_reg[31]};
    assign trial   = shifted - {1'b0, den_reg};

    // Iterate on magnitudes, then fix the signs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend[31] ? (32'd0 - dividend) : dividend;
            den_reg  <= divisor[31] ? (32'd0 - divisor) : divisor;
            rem_reg  <= '0;
            qneg_reg <= dividend[31] ^ divisor[31];
            rneg_reg <= dividend[31];
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign quotient  = qneg_reg ? (32'd0 - quo_reg) : quo_reg;
    assign remainder = rneg_reg ? (32'd0 - rem_reg[31:0]) : rem_reg[31:0];

endmodule
`default_nettype wire

### src/ism_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_back
// Executes instructions against the stack memory and emits result words.
// ----------------------------------------------------------------------------
module ism_back
    import ism_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    output logic        q_ready,
    input  wire instr_t q_word,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic [39:0] out_data,
    output logic        out_last
);

    logic [31:0] mem [StackDepth];
    logic [31:0] rd_data_reg;
    logic [AddrW-1:0] rd_addr, wr_addr;
    logic [31:0] wr_data;
    logic        wr_en;

    state_t      state_reg, state_next;
    instr_t      ins_reg, ins_next;
    logic [CountW-1:0] count_reg, count_next, idx_reg, idx_next;
    logic [31:0] top_reg, top_next, sec_reg, sec_next, res_reg, res_next;
    logic [31:0] mul_reg;
    logic [2:0]  stat_reg, stat_next;
    logic [31:0] oel_reg, oel_next;
    logic        ovld_reg, ovld_next, olast_reg, olast_next, oval_reg, oval_next;
    logic        div_start, div_done;
    logic [31:0] div_q, div_r;

    ism_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (sec_reg),
        .divisor   (top_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Stack memory, one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        mul_reg     <= sec_reg * top_reg;
    end

    assign out_valid = oval_reg;
    assign out_data  = {4'd0, ovld_reg, oel_reg, stat_reg};
    assign out_last  = olast_reg;
    assign q_ready   = (state_reg == S_IDLE) && !oval_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg   <= ins_next;
        idx_reg   <= idx_next;
        top_reg   <= top_next;
        sec_reg   <= sec_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
        oel_reg   <= oel_next;
        ovld_reg  <= ovld_next;
        olast_reg <= olast_next;
    end

    // Sequencer: next state, memory access and result word.
    always_comb
    begin
        state_next = state_reg;
        ins_next   = ins_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        top_next   = top_reg;
        sec_next   = sec_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        oel_next   = oel_reg;
        ovld_next  = ovld_reg;
        olast_next = olast_reg;
        oval_next  = oval_reg && !out_ready;
        rd_addr    = idx_reg[AddrW-1:0];
        wr_addr    = idx_reg[AddrW-1:0];
        wr_data    = res_reg;
        wr_en      = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !oval_reg)
                begin
                    ins_next  = q_word;
                    stat_next = ST_OK;
                    if (q_word.opcode == OP_LIST)
                    begin
                        if (count_reg == '0)
                        begin
                            oel_next   = '0;
                            ovld_next  = 1'b0;
                            olast_next = 1'b1;
                            oval_next  = 1'b1;
                        end
                        else
                        begin
                            idx_next   = count_reg - 1'b1;
                            state_next = S_LRD;
                        end
                    end
                    else
                    begin
                        idx_next   = count_reg - 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                // Top address is being read; set up the second below it.
                idx_next   = idx_reg - 1'b1;
                state_next = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                top_next   = rd_data_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                sec_next   = rd_data_reg;
                idx_next   = idx_reg;
                state_next = S_TOPRD;
                priority case (ins_reg.opcode)
                    OP_PUSH:
                    begin
                        if (!ins_reg.present)
                        begin
                            stat_next = ST_NOARG;
                        end
                        else if (count_reg == CountW'(StackDepth))
                        begin
                            stat_next = ST_FULL;
                        end
                        else
                        begin
                            res_next   = ins_reg.value;
                            idx_next   = count_reg;
                            state_next = S_WB1;
                        end
                    end
                    OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next = ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    OP_SWAP, OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_MOD:
                    begin
                        if (count_reg < CountW'(2))
                        begin
                            stat_next = ST_SHORT;
                        end
                        else if ((ins_reg.opcode == OP_DIV || ins_reg.opcode == OP_MOD)
                                 && top_reg == '0)
                        begin
                            stat_next = ST_DIVZERO;
                        end
                        else if (ins_reg.opcode == OP_DIV || ins_reg.opcode == OP_MOD)
                        begin
                            state_next = S_DIV;
                        end
                        else
                        begin
                            state_next = S_WB1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DIV:
            begin
                // Both operands are registered by now, so the divider starts here.
                div_start  = 1'b1;
                state_next = S_WB1;
            end
            S_WB1:
            begin
                priority case (ins_reg.opcode)
                    OP_PUSH:
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        state_next = S_TOPRD;
                    end
                    OP_SWAP:
                    begin
                        wr_data    = top_reg;
                        wr_en      = 1'b1;
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_WB2;
                    end
                    default:
                    begin
                        state_next = S_WB2;
                    end
                endcase
            end
            S_WB2:
            begin
                priority case (ins_reg.opcode)
                    OP_SWAP:
                    begin
                        wr_data    = sec_reg;
                        wr_en      = 1'b1;
                        state_next = S_TOPRD;
                    end
                    default:
                    begin
                        unique case (ins_reg.opcode)
                            OP_ADD:  wr_data = sec_reg + top_reg;
                            OP_SUB:  wr_data = sec_reg - top_reg;
                            OP_MUL:  wr_data = mul_reg;
                            OP_DIV:  wr_data = div_q;
                            default: wr_data = div_r;
                        endcase
                        if ((ins_reg.opcode == OP_DIV || ins_reg.opcode == OP_MOD)
                            && !div_done)
                        begin
                            wr_en      = 1'b0;
                            state_next = S_WB2;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg - 1'b1;
                            state_next = S_TOPRD;
                        end
                    end
                endcase
            end
            S_TOPRD:
            begin
                idx_next   = count_reg - 1'b1;
                state_next = S_TOPWAIT;
            end
            S_TOPWAIT:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                ovld_next  = (count_reg != '0);
                oel_next   = (count_reg != '0) ? rd_data_reg : '0;
                olast_next = 1'b1;
                oval_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_LRD:
            begin
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                state_next = S_LOUT;
            end
            S_LOUT:
            begin
                if (!oval_reg)
                begin
                    oel_next   = rd_data_reg;
                    ovld_next  = 1'b1;
                    olast_next = (idx_reg == '0);
                    oval_next  = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = S_LRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### src/integer_stack_machine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_stack_machine
// Bounded stack of 32-bit signed integers, one instruction per input word.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata: opcode[3:0], push_value[35:4], value_present[36]
// m_axis    out  tdata: status[2:0], element[34:3], element_valid[35]; tlast
//
// Div and mod wait for the divider, which makes one quotient bit per cycle.
// List all gives its words from the top of the stack down, each after its
// own registered memory read.
// Reset clears the item count; the stack memory needs no clearing.
// A two-word queue lets the host keep sending while results stall.
module integer_stack_machine
    import ism_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // opcode, push_value, value_present
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // status, element, element_valid
    output logic             m_axis_tlast
);

    instr_t in_word, q_word;
    logic   q_valid, q_ready;

    assign in_word.opcode  = s_axis_tdata[3:0];
    assign in_word.value   = s_axis_tdata[35:4];
    assign in_word.present = s_axis_tdata[36];

    ism_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_word  (in_word),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_word   (q_word)
    );

    ism_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_word    (q_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

### src/ism_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ism_checker
// Port-level checks for the integer stack machine.
// ----------------------------------------------------------------------------
module ism_checker
    import ism_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [39:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Status is one of the defined codes.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_FULL)
        else $error("undefined status code");

    // An error result always ends its instruction.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tlast)
        else $error("error result not marked last");

    // An empty element field is only shown on a final word.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[35] |-> m_axis_tlast && m_axis_tdata[34:3] == '0)
        else $error("empty element on a non-final word");

endmodule

bind integer_stack_machine ism_checker u_ism_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the integer stack machine. A short table of
// directed instructions covers errors, extremes and the overflowing divide,
// then random instruction streams run under three patterns of back-pressure.
// Every result word is compared against a behavioural stack model, or against the table row where it is typed.
// ----------------------------------------------------------------------------
module tb;
    import ism_pkg::*;

    localparam int  RandomItems = 480;
    localparam int  CycleLimit  = 2000000;
    localparam int  HoldCycles  = 400;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] val;
        logic        pres;
        bit          typed;
        status_t     st;
        logic [31:0] el;
        logic        ev;
    } instr_row_t;

    typedef struct {
        status_t     st;
        logic [31:0] el;
        logic        ev;
        logic        last;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // opcode, push_value, value_present
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // status, element, element_valid
    logic        m_axis_tlast;

    // Model state of the stack.
    logic [31:0] stack_words [StackDepth];
    int          depth_held;
    result_t     pending_results [$];
    instr_row_t  directed_rows [$];
    int          errors;
    int          accepted;
    int          phase;
    int          burst_left;
    longint      cycles;

    integer_stack_machine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Queue one result word that reports the current top of the stack.
    task automatic report_top(input status_t st);
        result_t r;
        r.st = st;
        r.last = 1'b1;
        if (depth_held > 0)
        begin
            r.el = stack_words[depth_held - 1];
            r.ev = 1'b1;
        end
        else
        begin
            r.el = '0;
            r.ev = 1'b0;
        end
        pending_results.push_back(r);
    endtask

    // Apply one instruction to the model stack and queue its result words.
    task automatic execute_instr(input logic [3:0] op, input logic [31:0] val,
                                 input logic pres);
        result_t     r;
        logic [31:0] top_w;
        logic [31:0] second_w;
        longint      sa;
        longint      sb;
        longint      q;
        status_t     st;
        st = ST_OK;
        if (op == OP_LIST)
        begin
            if (depth_held == 0)
            begin
                report_top(ST_OK);
            end
            else
            begin
                for (int i = depth_held; i > 0; i--)
                begin
                    r.st = ST_OK;
                    r.el = stack_words[i - 1];
                    r.ev = 1'b1;
                    r.last = (i == 1);
                    pending_results.push_back(r);
                end
            end
            return;
        end
        if (op == OP_PUSH)
        begin
            if (!pres)
                st = ST_NOARG;
            else if (depth_held >= StackDepth)
                st = ST_FULL;
            else
            begin
                stack_words[depth_held] = val;
                depth_held++;
            end
        end
        else if (op == OP_POP)
        begin
            if (depth_held == 0)
                st = ST_EMPTY;
            else
                depth_held--;
        end
        else if (op >= OP_SWAP && op <= OP_MOD)
        begin
            if (depth_held < 2)
                st = ST_SHORT;
            else
            begin
                top_w = stack_words[depth_held - 1];
                second_w = stack_words[depth_held - 2];
                sa = longint'($signed(second_w));
                sb = longint'($signed(top_w));
                if (op == OP_SWAP)
                begin
                    stack_words[depth_held - 1] = second_w;
                    stack_words[depth_held - 2] = top_w;
                end
                else if ((op == OP_DIV || op == OP_MOD) && top_w == 0)
                    st = ST_DIVZERO;
                else
                begin
                    case (op)
                        OP_ADD:  q = sa + sb;
                        OP_SUB:  q = sa - sb;
                        OP_DIV:  q = sa / sb;
                        OP_MUL:  q = sa * sb;
                        default: q = sa % sb;
                    endcase
                    stack_words[depth_held - 2] = q[31:0];
                    depth_held--;
                end
            end
        end
        report_top(st);
    endtask

    // Random operand, leaning towards extremes and small values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0;
            4, 5:    return 32'($signed($urandom_range(0, 20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    // Next random instruction: mostly sensible mixes, with bursts of pushes
    // that run the stack into its full state.
    task automatic next_random(output instr_row_t it);
        int r;
        it.typed = 1'b0;
        it.val = pick_operand();
        it.pres = 1'b1;
        if (burst_left > 0)
        begin
            burst_left--;
            it.op = OP_PUSH;
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = StackDepth + 3;
            it.op = OP_PUSH;
        end
        else if (r < 38)
        begin
            it.op = OP_PUSH;
            it.pres = ($urandom_range(0, 19) != 0);
        end
        else if (r < 44) it.op = OP_LIST;
        else if (r < 56) it.op = OP_POP;
        else if (r < 61) it.op = OP_SWAP;
        else if (r < 68) it.op = OP_ADD;
        else if (r < 75) it.op = OP_SUB;
        else if (r < 82) it.op = OP_DIV;
        else if (r < 88) it.op = OP_MUL;
        else if (r < 95) it.op = OP_MOD;
        else             it.op = 4'(OP_MOD + $urandom_range(1, 7));
        if ($urandom_range(0, 3) == 0)
            it.pres = 1'($urandom_range(0, 1));
    endtask

    task automatic add_row(input logic [3:0] op, input logic [31:0] val,
                           input logic pres, input bit typed, input status_t st,
                           input logic [31:0] el, input logic ev);
        instr_row_t row;
        row.op = op;
        row.val = val;
        row.pres = pres;
        row.typed = typed;
        row.st = st;
        row.el = el;
        row.ev = ev;
        directed_rows.push_back(row);
    endtask

    // Run timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, and word checking.
    initial
    begin
        int     hold_left;
        bit     held;
        result_t exp_r;
        logic [2:0] got_st;
        hold_left = 0;
        held = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_st = m_axis_tdata[2:0];
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word st=%0d el=%h ev=%b last=%b", $time,
                             got_st, m_axis_tdata[34:3], m_axis_tdata[35], m_axis_tlast);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (got_st != exp_r.st || m_axis_tdata[34:3] != exp_r.el
                        || m_axis_tdata[35] != exp_r.ev || m_axis_tlast != exp_r.last)
                    begin
                        errors++;
                        $display("%0t: mismatch expected st=%0d el=%h ev=%b last=%b",
                                 $time, exp_r.st, exp_r.el, exp_r.ev, exp_r.last);
                        $display("%0t:          actual   st=%0d el=%h ev=%b last=%b",
                                 $time, got_st, m_axis_tdata[34:3], m_axis_tdata[35],
                                 m_axis_tlast);
                    end
                end
            end
            // A long stall once the idle-free phase starts fills the block.
            if (phase == 2 && !held)
            begin
                held = 1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (phase == 0)
                m_axis_tready <= ($urandom_range(0, 99) >= 66);
            else if (phase == 1)
                m_axis_tready <= ($urandom_range(0, 99) >= 24);
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Instruction side and end of run.
    initial
    begin
        instr_row_t cur;
        instr_row_t nxt;
        int         dir_idx;
        int         rand_done;
        int         idle_pct;
        int         drain;
        bit         have_next;
        errors = 0;
        accepted = 0;
        phase = 0;
        burst_left = 0;
        cycles = 0;
        depth_held = 0;
        dir_idx = 0;
        rand_done = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;

        add_row(OP_LIST, 32'h0, 1'b1, 1, ST_OK, 32'h0, 1'b0);
        add_row(OP_POP, 32'h0, 1'b1, 1, ST_EMPTY, 32'h0, 1'b0);
        add_row(OP_ADD, 32'h0, 1'b1, 1, ST_SHORT, 32'h0, 1'b0);
        add_row(OP_PUSH, 32'h5, 1'b0, 1, ST_NOARG, 32'h0, 1'b0);
        add_row(OP_PUSH, 32'h8000_0000, 1'b1, 1, ST_OK, 32'h8000_0000, 1'b1);
        add_row(OP_SWAP, 32'h0, 1'b1, 1, ST_SHORT, 32'h8000_0000, 1'b1);
        add_row(OP_DIV, 32'h0, 1'b1, 1, ST_SHORT, 32'h8000_0000, 1'b1);
        add_row(OP_PUSH, 32'hFFFF_FFFF, 1'b1, 1, ST_OK, 32'hFFFF_FFFF, 1'b1);
        add_row(OP_DIV, 32'h0, 1'b1, 1, ST_OK, 32'h8000_0000, 1'b1);
        add_row(OP_PUSH, 32'hFFFF_FFFF, 1'b1, 0, ST_OK, 32'h0, 1'b0);
        add_row(OP_MOD, 32'h0, 1'b1, 1, ST_OK, 32'h0, 1'b1);
        add_row(OP_PUSH, 32'h0, 1'b1, 1, ST_OK, 32'h0, 1'b1);
        add_row(OP_DIV, 32'h0, 1'b1, 1, ST_DIVZERO, 32'h0, 1'b1);
        add_row(OP_MOD, 32'h0, 1'b1, 1, ST_DIVZERO, 32'h0, 1'b1);
        add_row(OP_PUSH, 32'h7FFF_FFFF, 1'b1, 0, ST_OK, 32'h0, 1'b0);
        add_row(OP_PUSH, 32'h1, 1'b1, 0, ST_OK, 32'h0, 1'b0);
        add_row(OP_ADD, 32'h0, 1'b1, 0, ST_OK, 32'h0, 1'b0);
        add_row(OP_PUSH, 32'h7FFF_FFFF, 1'b1, 0, ST_OK, 32'h0, 1'b0);
        add_row(OP_MUL, 32'h0, 1'b1, 0, ST_OK, 32'h0, 1'b0);
        add_row(OP_PUSH, 32'hFFFF_FFF9, 1'b1, 0, ST_OK, 32'h0, 1'b0);
        add_row(OP_SUB, 32'h0, 1'b1, 0, ST_OK, 32'h0, 1'b0);
        add_row(OP_SWAP, 32'h0, 1'b1, 0, ST_OK, 32'h0, 1'b0);
        add_row(OP_LIST, 32'h0, 1'b1, 0, ST_OK, 32'h0, 1'b0);
        add_row(4'hF, 32'h0, 1'b1, 0, ST_OK, 32'h0, 1'b0);
        add_row(OP_POP, 32'h0, 1'b1, 0, ST_OK, 32'h0, 1'b0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        forever
        begin
            @(posedge clk);
            // Word taken: update the model, with typed rows overriding it.
            if (s_axis_tvalid && s_axis_tready)
            begin
                execute_instr(cur.op, cur.val, cur.pres);
                if (cur.typed)
                begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(result_t'{cur.st, cur.el, cur.ev, 1'b1});
                end
                accepted++;
                phase = (accepted < 170) ? 0 : (accepted < 340) ? 1 : 2;
            end
            if (s_axis_tvalid && !s_axis_tready)
                continue;
            have_next = 1'b1;
            if (dir_idx < directed_rows.size())
                nxt = directed_rows[dir_idx];
            else if (rand_done < RandomItems)
                next_random(nxt);
            else
                have_next = 1'b0;
            if (!have_next)
            begin
                s_axis_tvalid <= 1'b0;
                break;
            end
            idle_pct = (phase == 0) ? 24 : (phase == 1) ? 66 : 0;
            if ($urandom_range(0, 99) < idle_pct)
            begin
                // Random instructions drawn but not sent are simply dropped.
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                if (dir_idx < directed_rows.size())
                    dir_idx++;
                else
                    rand_done++;
                cur = nxt;
                s_axis_tdata <= {3'b000, nxt.pres, nxt.val, nxt.op};
                s_axis_tvalid <= 1'b1;
            end
        end

        // Wait for every outstanding word, then a short quiet period.
        while (pending_results.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 100)
        begin
            @(posedge clk);
            drain++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
src/ism_pkg.sv
src/ism_front.sv
src/ism_div.sv
src/ism_back.sv
src/integer_stack_machine.sv
src/ism_checker.sv
tb/tb.sv
